FILE: rtl/pst_pkg.sv
package pst_pkg;

  localparam int OP_W   = 2;
  localparam int PRIO_W = 32;
  localparam int TAG_W  = 64;
  localparam int SLOT_W = 10;
  localparam int SUM_W  = 42;
  localparam int CNT_W  = 11;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

endpackage

FILE: rtl/priority_sum_tree_sampler.sv
// Sum tree for prioritized replay over LEAF_COUNT slots (a power of two). The node sums
// live in one memory in heap order (root at 0, children of n at 2n+1 and 2n+2).
// Tags live in a second memory. Both have one write port and registered reads.
// After reset the block clears all 2*LEAF_COUNT-1 nodes and the tags, and holds in_ready
// low until it is done. Add and update read the old leaf and write the new priority.
// They then walk up one ancestor per cycle, reading the next ancestor while writing the
// current one. Sample descends one level per cycle: both children are read together,
// and the compare picks the next pair. The block works on one item at a time. A finished
// result waits in the output register, so the next item can be accepted meanwhile.
// The root sum is also kept in a register and reported as total_priority.
module priority_sum_tree_sampler
  import pst_pkg::*;
#(
  parameter int LEAF_COUNT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   op,
  input  logic [PRIO_W-1:0] priority_req,
  input  logic [TAG_W-1:0]  tag,
  input  logic [SLOT_W-1:0] slot,
  input  logic [SUM_W-1:0]  target,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] found_slot,
  output logic [PRIO_W-1:0] found_priority,
  output logic [TAG_W-1:0]  found_tag,
  output logic [SUM_W-1:0]  total_priority,
  output logic [CNT_W-1:0]  entry_count
);

  localparam int LW         = $clog2(LEAF_COUNT);
  localparam int NW         = LW + 1;
  localparam int CW         = LW + 1;
  localparam int NODE_COUNT = 2 * LEAF_COUNT - 1;

  localparam logic [NW-1:0] LEAF_BASE = NW'(LEAF_COUNT - 1);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);
  localparam logic [CW-1:0] FULL      = CW'(LEAF_COUNT);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LEAF,
    S_UP,
    S_DESC,
    S_TAG,
    S_DONE
  } state_t;

  state_t state;

  logic [SUM_W-1:0] node_mem [0:NODE_COUNT-1];
  logic [TAG_W-1:0] tag_mem  [0:LEAF_COUNT-1];

  logic [NW-1:0]     clr_idx;
  logic [NW-1:0]     node;
  logic [SUM_W-1:0]  diff;
  logic [SUM_W-1:0]  tgt;
  logic [PRIO_W-1:0] prio_r;
  logic [LW-1:0]     leaf_slot;
  logic [TAG_W-1:0]  res_tag;
  logic              is_update;
  logic [SUM_W-1:0]  total;
  logic [LW-1:0]     wptr;
  logic [CW-1:0]     filled;

  logic              n_we;
  logic [NW-1:0]     n_wa;
  logic [SUM_W-1:0]  n_wd;
  logic [NW-1:0]     n_ra;
  logic [NW-1:0]     n_rb;
  logic [SUM_W-1:0]  n_rd_a;
  logic [SUM_W-1:0]  n_rd_b;
  logic              t_we;
  logic [LW-1:0]     t_wa;
  logic [TAG_W-1:0]  t_wd;
  logic [LW-1:0]     t_ra;
  logic [TAG_W-1:0]  t_rd;

  logic              in_xfer;
  logic [LW-1:0]     slot_idx;
  logic [NW-1:0]     parent;
  logic [SUM_W-1:0]  diff_c;
  logic              go_left;
  logic [NW-1:0]     child;
  logic              child_is_leaf;
  logic [NW-1:0]     child_slot;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign slot_idx = LW'(slot);
  assign parent   = (node - NW'(1)) >> 1;
  assign diff_c   = SUM_W'(prio_r) - n_rd_a;
  assign go_left  = (tgt <= n_rd_a);
  assign child    = {node[NW-2:0], 1'b0} + (go_left ? NW'(1) : NW'(2));
  assign child_is_leaf = (child >= LEAF_BASE);
  assign child_slot    = child - LEAF_BASE;

  always_comb begin
    n_we = 1'b0;
    n_wa = node;
    n_wd = '0;
    n_ra = '0;
    n_rb = '0;
    t_we = 1'b0;
    t_wa = wptr;
    t_wd = tag;
    t_ra = slot_idx;
    case (state)
      S_CLEAR: begin
        n_we = 1'b1;
        n_wa = clr_idx;
        n_wd = '0;
        t_we = (clr_idx < NW'(LEAF_COUNT));
        t_wa = LW'(clr_idx);
        t_wd = '0;
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (op)
            OP_ADD: begin
              t_we = 1'b1;
              n_ra = NW'(wptr) + LEAF_BASE;
            end
            OP_UPDATE: begin
              n_ra = NW'(slot_idx) + LEAF_BASE;
            end
            OP_SAMPLE: begin
              n_ra = NW'(1);
              n_rb = NW'(2);
            end
            default: begin
            end
          endcase
        end
      end
      S_LEAF: begin
        n_we = 1'b1;
        n_wa = node;
        n_wd = SUM_W'(prio_r);
        n_ra = parent;
      end
      S_UP: begin
        n_we = 1'b1;
        n_wa = node;
        n_wd = n_rd_a + diff;
        n_ra = parent;
      end
      S_DESC: begin
        n_ra = {child[NW-2:0], 1'b0} + NW'(1);
        n_rb = {child[NW-2:0], 1'b0} + NW'(2);
        t_ra = LW'(child_slot);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      node_mem[n_wa] <= n_wd;
    end
    n_rd_a <= node_mem[n_ra];
    n_rd_b <= node_mem[n_rb];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tag_mem[t_wa] <= t_wd;
    end
    t_rd <= tag_mem[t_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      total     <= '0;
      wptr      <= '0;
      filled    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + NW'(1);
          if (clr_idx == LAST_NODE) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            case (op)
              OP_ADD: begin
                node      <= NW'(wptr) + LEAF_BASE;
                leaf_slot <= wptr;
                prio_r    <= priority_req;
                res_tag   <= tag;
                is_update <= 1'b0;
                wptr      <= wptr + LW'(1);
                if (filled != FULL) begin
                  filled <= filled + CW'(1);
                end
                state <= S_LEAF;
              end
              OP_UPDATE: begin
                node      <= NW'(slot_idx) + LEAF_BASE;
                leaf_slot <= slot_idx;
                prio_r    <= priority_req;
                is_update <= 1'b1;
                state     <= S_LEAF;
              end
              OP_SAMPLE: begin
                node  <= '0;
                tgt   <= target;
                state <= S_DESC;
              end
              default: begin
                leaf_slot <= '0;
                prio_r    <= '0;
                res_tag   <= '0;
                state     <= S_DONE;
              end
            endcase
          end
        end
        S_LEAF: begin
          diff  <= diff_c;
          total <= total + diff_c;
          if (is_update) begin
            res_tag <= t_rd;
          end
          node  <= parent;
          state <= S_UP;
        end
        S_UP: begin
          if (node == '0) begin
            state <= S_DONE;
          end else begin
            node <= parent;
          end
        end
        S_DESC: begin
          if (!go_left) begin
            tgt <= tgt - n_rd_a;
          end
          if (child_is_leaf) begin
            leaf_slot <= LW'(child_slot);
            prio_r    <= go_left ? n_rd_a[PRIO_W-1:0] : n_rd_b[PRIO_W-1:0];
            state     <= S_TAG;
          end else begin
            node <= child;
          end
        end
        S_TAG: begin
          res_tag <= t_rd;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            found_slot     <= SLOT_W'(leaf_slot);
            found_priority <= prio_r;
            found_tag      <= res_tag;
            total_priority <= total;
            entry_count    <= CNT_W'(filled);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb.sv
module tb
  import pst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEAVES = 1024;
  localparam int NODES  = 2 * LEAVES - 1;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] slot;
    logic [SUM_W-1:0]  target;
  } request_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    logic [SUM_W-1:0]  total;
    logic [CNT_W-1:0]  count;
  } reply_t;

  class sum_tree_board;
    bit [SUM_W-1:0]  node_sum [NODES];
    bit [TAG_W-1:0]  tag_mem [LEAVES];
    bit [SLOT_W-1:0] wr_ptr;
    bit [CNT_W-1:0]  fill_cnt;
    int unsigned     mismatches;
    reply_t          pending_replies[$];

    function void write_leaf(int unsigned s, bit [PRIO_W-1:0] p);
      int unsigned n;
      bit [SUM_W-1:0] diff;
      n = s + LEAVES - 1;
      diff = SUM_W'(p) - node_sum[n];
      node_sum[n] = SUM_W'(p);
      while (n != 0) begin
        n = (n - 1) / 2;
        node_sum[n] = node_sum[n] + diff;
      end
    endfunction

    function int unsigned walk_down(bit [SUM_W-1:0] t);
      int unsigned n;
      int unsigned l;
      n = 0;
      while (2 * n + 1 < NODES) begin
        l = 2 * n + 1;
        if (t <= node_sum[l]) begin
          n = l;
        end else begin
          t = t - node_sum[l];
          n = l + 1;
        end
      end
      return n - (LEAVES - 1);
    endfunction

    function bit [SUM_W-1:0] leaf_prefix(int unsigned k);
      bit [SUM_W-1:0] acc;
      acc = '0;
      for (int unsigned i = 0; i <= k; i++) acc = acc + node_sum[LEAVES - 1 + i];
      return acc;
    endfunction

    function void take_request(request_t r);
      reply_t e;
      int unsigned s;
      s = 0;
      e = '0;
      case (r.op)
        OP_ADD: begin
          s = 32'(wr_ptr);
          tag_mem[s] = r.tag;
          write_leaf(s, r.prio);
          wr_ptr = (s == LEAVES - 1) ? '0 : SLOT_W'(s + 1);
          if (fill_cnt < LEAVES) fill_cnt++;
        end
        OP_UPDATE: begin
          s = r.slot % LEAVES;
          write_leaf(s, r.prio);
        end
        OP_SAMPLE: begin
          s = walk_down(r.target);
        end
        default: ;
      endcase
      if (r.op != OP_UNUSED) begin
        e.slot = SLOT_W'(s);
        e.prio = node_sum[s + LEAVES - 1][PRIO_W-1:0];
        e.tag  = tag_mem[s];
      end
      e.total = node_sum[0];
      e.count = fill_cnt;
      pending_replies = {pending_replies, e};
    endfunction

    function void check_reply(reply_t got);
      reply_t e;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: slot %0d prio %h total %h", got.slot, got.prio,
                   got.total);
        return;
      end
      e = pending_replies.pop_front();
      if (got.slot !== e.slot || got.prio !== e.prio || got.tag !== e.tag ||
          got.total !== e.total || got.count !== e.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch (exp/got): slot %0d/%0d prio %h/%h tag %h/%h total %h/%h count %0d/%0d",
                   e.slot, got.slot, e.prio, got.prio, e.tag, got.tag, e.total, got.total,
                   e.count, got.count);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   op;
  logic [PRIO_W-1:0] priority_req;
  logic [TAG_W-1:0]  tag;
  logic [SLOT_W-1:0] slot;
  logic [SUM_W-1:0]  target;
  logic              out_valid;
  logic              out_ready;
  logic [SLOT_W-1:0] found_slot;
  logic [PRIO_W-1:0] found_priority;
  logic [TAG_W-1:0]  found_tag;
  logic [SUM_W-1:0]  total_priority;
  logic [CNT_W-1:0]  entry_count;

  sum_tree_board board = new();

  bit          quiet;
  int unsigned in_gap_pct;
  int unsigned out_gap_pct;
  int unsigned sent_count;

  priority_sum_tree_sampler #(
    .LEAF_COUNT(LEAVES)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .priority_req  (priority_req),
    .tag           (tag),
    .slot          (slot),
    .target        (target),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found_slot    (found_slot),
    .found_priority(found_priority),
    .found_tag     (found_tag),
    .total_priority(total_priority),
    .entry_count   (entry_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_reply({found_slot, found_priority, found_tag, total_priority, entry_count});
  end

  // result side back-pressure
  initial begin
    int unsigned hold;
    int unsigned cyc;
    hold = 0;
    cyc = 0;
    out_ready = 1'b0;
    out_gap_pct = 10;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 200 == 0) begin
        case ($urandom_range(0, 2))
          0: out_gap_pct = 0;
          1: out_gap_pct = 10;
          default: out_gap_pct = 40;
        endcase
      end
      if (quiet) hold = 0;
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < out_gap_pct) hold = $urandom_range(1, 13);
      end
    end
  end

  task automatic pause_input(int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_request(request_t r);
    @(negedge clk);
    in_valid     <= 1'b1;
    op           <= r.op;
    priority_req <= r.prio;
    tag          <= r.tag;
    slot         <= r.slot;
    target       <= r.target;
    do @(posedge clk); while (!in_ready);
    board.take_request(r);
    sent_count++;
    if (sent_count % 40 == 0) begin
      case ($urandom_range(0, 2))
        0: in_gap_pct = 0;
        1: in_gap_pct = 15;
        default: in_gap_pct = 50;
      endcase
    end
    if (!quiet && $urandom_range(0, 99) < in_gap_pct) pause_input($urandom_range(1, 13));
  endtask

  task automatic send_fields(logic [OP_W-1:0] o, logic [PRIO_W-1:0] p, logic [TAG_W-1:0] t,
                             logic [SLOT_W-1:0] s, logic [SUM_W-1:0] g);
    request_t r;
    r.op = o;
    r.prio = p;
    r.tag = t;
    r.slot = s;
    r.target = g;
    send_request(r);
  endtask

  function automatic logic [PRIO_W-1:0] random_priority();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return $urandom_range(0, 32'h0001_0000);
      5, 6: return $urandom_range(0, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] random_target();
    bit [63:0] tot;
    tot = 64'(board.node_sum[0]);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return board.leaf_prefix($urandom_range(0, LEAVES - 1));
      2: return board.leaf_prefix($urandom_range(0, LEAVES - 1)) + 1'b1;
      3: return SUM_W'(tot + $urandom_range(1, 1000));
      4: return '1;
      5: return SUM_W'({$urandom, $urandom});
      default: return SUM_W'({$urandom, $urandom} % (tot + 1));
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) r.op = OP_ADD;
    else if (pick < 60) r.op = OP_UPDATE;
    else if (pick < 95) r.op = OP_SAMPLE;
    else r.op = OP_UNUSED;
    r.prio = random_priority();
    r.tag = {$urandom, $urandom};
    if (board.fill_cnt != 0 && $urandom_range(0, 3) != 0)
      r.slot = SLOT_W'($urandom_range(0, board.fill_cnt - 1));
    else
      r.slot = SLOT_W'($urandom);
    r.target = random_target();
    return r;
  endfunction

  initial begin
    request_t r;
    in_valid = 1'b0;
    op = OP_ADD;
    priority_req = '0;
    tag = '0;
    slot = '0;
    target = '0;
    quiet = 1'b0;
    in_gap_pct = 15;
    sent_count = 0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty tree, unused code, extremes of every field
    send_fields(OP_SAMPLE, '0, '0, '0, '0);
    send_fields(OP_SAMPLE, '1, '1, '1, '1);
    send_fields(OP_UNUSED, '1, '1, '1, '1);
    send_fields(OP_ADD, '0, '0, '0, '0);
    send_fields(OP_ADD, '1, '1, '1, '1);
    send_fields(OP_ADD, 32'd1, 64'h0123_4567_89ab_cdef, '0, '0);
    send_fields(OP_ADD, 32'h0001_0000, {$urandom, $urandom}, '0, '0);
    send_fields(OP_UPDATE, '0, '0, 10'd1, '0);
    send_fields(OP_UPDATE, '1, '0, '1, '0);
    send_fields(OP_UPDATE, 32'h8000_0000, '1, '0, '1);
    send_fields(OP_UPDATE, 32'd1, '0, 10'd2, '0);
    send_fields(OP_SAMPLE, '0, '0, '0, '0);
    // target equal to a left sum goes left, one above goes right
    send_fields(OP_SAMPLE, '0, '0, '0, board.leaf_prefix(0));
    send_fields(OP_SAMPLE, '0, '0, '0, board.leaf_prefix(0) + 1'b1);
    send_fields(OP_SAMPLE, '0, '0, '0, board.leaf_prefix(511));
    send_fields(OP_SAMPLE, '0, '0, '0, board.node_sum[0]);
    send_fields(OP_SAMPLE, '0, '0, '0, board.node_sum[0] + 1'b1);
    send_fields(OP_SAMPLE, '0, '0, '0, '1);
    send_fields(OP_UPDATE, '0, '1, '1, '0);
    send_fields(OP_SAMPLE, '0, '0, '0, board.node_sum[0] + 1'b1);
    send_fields(OP_UNUSED, '0, '0, '0, '0);

    repeat (220) send_request(random_request());

    // mostly adds
    repeat (100) begin
      r = random_request();
      if ($urandom_range(0, 4) != 0) r.op = OP_ADD;
      send_request(r);
    end

    quiet = 1'b1;
    repeat (60) send_request(random_request());
    pause_input(1);

    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
